>>> src/telemetry_frame_serializer_macros.svh
// Assertion macros shared by the telemetry frame serializer RTL.
`ifndef TELEMETRY_FRAME_SERIALIZER_MACROS_SVH
`define TELEMETRY_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfs assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define TFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfs assertion failed");

`endif

>>> src/tfs_pkg.sv
// Types, constants and frame-layout functions for the telemetry frame serializer.
package tfs_pkg;

	localparam int unsigned PayloadMax = 13;
	localparam int unsigned PayloadW   = PayloadMax * 8;

	typedef logic [2:0]          kind_t;
	typedef logic [4:0]          idx_t;
	typedef logic [3:0]          pidx_t;
	typedef logic [7:0]          byte_t;
	typedef logic [PayloadW-1:0] payload_t;

	localparam kind_t KIND_ATT    = 3'd0;
	localparam kind_t KIND_IMU    = 3'd1;
	localparam kind_t KIND_MOTOR  = 3'd2;
	localparam kind_t KIND_TARGET = 3'd3;
	localparam kind_t KIND_SPEED  = 3'd4;
	localparam kind_t KIND_ACK    = 3'd5;
	localparam kind_t KIND_PARAM  = 3'd6;

	localparam byte_t HDR_SYNC = 8'hAA;
	localparam byte_t HDR_ADDR = 8'hFF;

	localparam byte_t ID_ATT    = 8'h03;
	localparam byte_t ID_IMU    = 8'h01;
	localparam byte_t ID_MOTOR  = 8'h21;
	localparam byte_t ID_TARGET = 8'h0A;
	localparam byte_t ID_SPEED  = 8'h07;
	localparam byte_t ID_ACK    = 8'h00;
	localparam byte_t ID_PARAM  = 8'hE2;

	localparam idx_t  IDX_HDR_SYNC = 5'd0;
	localparam idx_t  IDX_HDR_ADDR = 5'd1;
	localparam idx_t  IDX_ID       = 5'd2;
	localparam idx_t  IDX_LEN      = 5'd3;
	localparam idx_t  IDX_PAYLOAD  = 5'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BODY,
		ST_SUM,
		ST_ADD
	} state_t;

	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_BODY,
		SEL_SUM,
		SEL_ADD
	} sel_t;

	typedef struct packed {
		logic capture;
		logic load;
		sel_t sel;
		idx_t idx;
	} seq_ctrl_t;

	function automatic logic kind_valid(input kind_t k);
		return k <= KIND_PARAM;
	endfunction

	function automatic byte_t frame_id(input kind_t k);
		byte_t id;
		unique case (k)
			KIND_ATT:    id = ID_ATT;
			KIND_IMU:    id = ID_IMU;
			KIND_MOTOR:  id = ID_MOTOR;
			KIND_TARGET: id = ID_TARGET;
			KIND_SPEED:  id = ID_SPEED;
			KIND_ACK:    id = ID_ACK;
			KIND_PARAM:  id = ID_PARAM;
			default:     id = ID_ACK;
		endcase
		return id;
	endfunction

	function automatic pidx_t payload_len(input kind_t k);
		pidx_t len;
		unique case (k)
			KIND_ATT:    len = 4'd7;
			KIND_IMU:    len = 4'd13;
			KIND_MOTOR:  len = 4'd8;
			KIND_TARGET: len = 4'd6;
			KIND_SPEED:  len = 4'd6;
			KIND_ACK:    len = 4'd3;
			KIND_PARAM:  len = 4'd6;
			default:     len = 4'd0;
		endcase
		return len;
	endfunction

	// Payload bytes packed low byte first: byte j sits at [8*j +: 8].
	function automatic payload_t payload_pack(
		input kind_t              k,
		input logic signed [15:0] a,
		input logic signed [15:0] b,
		input logic signed [15:0] c,
		input logic signed [15:0] d,
		input logic signed [15:0] e,
		input logic signed [15:0] f,
		input byte_t              status,
		input logic [15:0]        id,
		input logic signed [31:0] pv,
		input byte_t              asum,
		input byte_t              aadd
	);
		payload_t p;
		p = '0;
		unique case (k) inside
			KIND_ATT:                p[55:0]  = {status, c, b, a};
			KIND_IMU:                p[103:0] = {status, f, e, d, c, b, a};
			KIND_MOTOR:              p[63:0]  = {d, c, b, a};
			KIND_TARGET, KIND_SPEED: p[47:0]  = {c, b, a};
			KIND_ACK:                p[23:0]  = {aadd, asum, id[7:0]};
			KIND_PARAM:              p[47:0]  = {pv, id};
			default:                 p        = '0;
		endcase
		return p;
	endfunction

endpackage

>>> src/tfs_seq.sv
// Frame sequencer: request capture, byte index counter and check-byte steps.
module tfs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tfs_pkg::kind_t      kind,
	input  logic                step,
	output logic                in_ready,
	output tfs_pkg::seq_ctrl_t  ctrl
);

	tfs_pkg::state_t state_q, state_d;
	tfs_pkg::idx_t   idx_q;
	tfs_pkg::idx_t   last_idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfs_pkg::ST_IDLE: begin
				if (in_valid && tfs_pkg::kind_valid(kind))
					state_d = tfs_pkg::ST_BODY;
			end
			tfs_pkg::ST_BODY: begin
				if (step && idx_q == last_idx_q)
					state_d = tfs_pkg::ST_SUM;
			end
			tfs_pkg::ST_SUM: begin
				if (step)
					state_d = tfs_pkg::ST_ADD;
			end
			tfs_pkg::ST_ADD: begin
				if (step)
					state_d = tfs_pkg::ST_IDLE;
			end
			default: state_d = tfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == tfs_pkg::ST_IDLE);
		ctrl.capture = in_valid && in_ready && tfs_pkg::kind_valid(kind);
		ctrl.load    = step && (state_q != tfs_pkg::ST_IDLE);
		ctrl.idx     = idx_q;
		unique case (state_q)
			tfs_pkg::ST_BODY: ctrl.sel = tfs_pkg::SEL_BODY;
			tfs_pkg::ST_SUM:  ctrl.sel = tfs_pkg::SEL_SUM;
			tfs_pkg::ST_ADD:  ctrl.sel = tfs_pkg::SEL_ADD;
			default:          ctrl.sel = tfs_pkg::SEL_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tfs_pkg::ST_IDLE;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.capture) begin
				idx_q      <= '0;
				// header is four bytes, so the last body index is len + 3
				last_idx_q <= tfs_pkg::idx_t'({1'b0, tfs_pkg::payload_len(kind)} + 5'd3);
			end else if (ctrl.load && ctrl.sel == tfs_pkg::SEL_BODY) begin
				idx_q <= tfs_pkg::idx_t'(idx_q + 5'd1);
			end
		end
	end

endmodule

>>> src/tfs_frame_mux.sv
// Frame body byte select: header, id, length, then captured payload bytes.
module tfs_frame_mux (
	input  tfs_pkg::kind_t    kind_q,
	input  tfs_pkg::payload_t payload_q,
	input  tfs_pkg::idx_t     idx,
	output tfs_pkg::byte_t    body_byte
);

	tfs_pkg::pidx_t pidx;
	tfs_pkg::byte_t pbyte;

	assign pidx = tfs_pkg::pidx_t'(idx - tfs_pkg::IDX_PAYLOAD);

	always_comb begin
		pbyte = '0;
		if (pidx < tfs_pkg::pidx_t'(tfs_pkg::PayloadMax))
			pbyte = payload_q[pidx*8 +: 8];
	end

	always_comb begin
		unique case (idx)
			tfs_pkg::IDX_HDR_SYNC: body_byte = tfs_pkg::HDR_SYNC;
			tfs_pkg::IDX_HDR_ADDR: body_byte = tfs_pkg::HDR_ADDR;
			tfs_pkg::IDX_ID:       body_byte = tfs_pkg::frame_id(kind_q);
			tfs_pkg::IDX_LEN:      body_byte = {4'd0, tfs_pkg::payload_len(kind_q)};
			default:               body_byte = pbyte;
		endcase
	end

endmodule

>>> src/tfs_check.sv
// Shared check unit: running sum and sum of running sums, one byte per cycle while add_en is high.
module tfs_check (
	input  logic           clk,
	input  logic           clr,
	input  logic           add_en,
	input  tfs_pkg::byte_t din,
	output tfs_pkg::byte_t sum_q,
	output tfs_pkg::byte_t add_q
);

	tfs_pkg::byte_t sum_d;

	assign sum_d = tfs_pkg::byte_t'(sum_q + din);

	always_ff @(posedge clk) begin
		if (clr) begin
			sum_q <= '0;
			add_q <= '0;
		end else if (add_en) begin
			sum_q <= sum_d;
			add_q <= tfs_pkg::byte_t'(add_q + sum_d);
		end
	end

endmodule

>>> src/telemetry_frame_serializer.sv
// Telemetry frame serializer top level: request capture, sequencing and byte output.
// One request (kind plus value fields) is captured; the block then
// drops in_ready and emits the frame one word per cycle while out_ready is held high:
// 0xAA 0xFF, frame id, payload length, payload (16-bit values low byte first), the
// 8-bit running sum and the 8-bit sum of running sums, with last_byte set on that final
// add-check word. Frames are 9 to 19 words long (acknowledge shortest, accel/gyro
// longest) and a request occupies the block until its frame is loaded, paced by the
// sequencer's byte counter and the single check adder pair that folds in each body word
// as it is loaded. Backpressure on out_ready simply pauses the sequence; the output
// register holds the current word. Kind 7 is taken and dropped with no words. After
// the add-check word is loaded, in_ready rises again while that word still waits.
`include "telemetry_frame_serializer_macros.svh"

module telemetry_frame_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [15:0] value_a,
	input  logic signed [15:0] value_b,
	input  logic signed [15:0] value_c,
	input  logic signed [15:0] value_d,
	input  logic signed [15:0] value_e,
	input  logic signed [15:0] value_f,
	input  logic [7:0]         status_byte,
	input  logic [15:0]        item_id,
	input  logic signed [31:0] param_value,
	input  logic [7:0]         ack_sum,
	input  logic [7:0]         ack_add,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	tfs_pkg::seq_ctrl_t seq_ctrl;
	tfs_pkg::kind_t     kind_q;
	tfs_pkg::payload_t  payload_q;
	tfs_pkg::byte_t     body_byte;
	tfs_pkg::byte_t     sum_q;
	tfs_pkg::byte_t     add_q;
	tfs_pkg::byte_t     next_byte;
	logic               step;
	logic               load_body;
	logic               load_add;
	logic               at_sync;
	logic               out_valid_q;
	tfs_pkg::byte_t     frame_byte_q;
	logic               last_byte_q;

	// output register can take a new word when empty or being drained
	assign step = !out_valid_q || out_ready;

	tfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.step     (step),
		.in_ready (in_ready),
		.ctrl     (seq_ctrl)
	);

	assign load_body = seq_ctrl.load && seq_ctrl.sel == tfs_pkg::SEL_BODY;
	assign load_add  = seq_ctrl.load && seq_ctrl.sel == tfs_pkg::SEL_ADD;
	assign at_sync   = load_body && seq_ctrl.idx == tfs_pkg::IDX_HDR_SYNC;

	// request capture; payload is pre-packed so the mux only indexes bytes
	always_ff @(posedge clk) begin
		if (seq_ctrl.capture) begin
			kind_q    <= kind;
			payload_q <= tfs_pkg::payload_pack(kind, value_a, value_b, value_c, value_d,
				value_e, value_f, status_byte, item_id, param_value, ack_sum, ack_add);
		end
	end

	tfs_frame_mux u_mux (
		.kind_q    (kind_q),
		.payload_q (payload_q),
		.idx       (seq_ctrl.idx),
		.body_byte (body_byte)
	);

	tfs_check u_check (
		.clk    (clk),
		.clr    (seq_ctrl.capture),
		.add_en (load_body),
		.din    (body_byte),
		.sum_q  (sum_q),
		.add_q  (add_q)
	);

	always_comb begin
		case (seq_ctrl.sel)
			tfs_pkg::SEL_SUM: next_byte = sum_q;
			tfs_pkg::SEL_ADD: next_byte = add_q;
			default:          next_byte = body_byte;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ctrl.load) begin
			frame_byte_q <= next_byte;
			last_byte_q  <= (seq_ctrl.sel == tfs_pkg::SEL_ADD);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	// a captured request holds off the next one until its frame is loaded
	`TFS_ASSERT_NEXT(a_busy_after_capture, seq_ctrl.capture, !in_ready)
	// the add-check word shows up next cycle flagged as last
	`TFS_ASSERT_NEXT(a_add_is_last, load_add, out_valid && last_byte)
	// every frame opens with the sync byte
	`TFS_ASSERT_IMP(a_sync_first, at_sync, body_byte == tfs_pkg::HDR_SYNC)

endmodule

>>> sim/telemetry_frame_serializer_chk.sv
`timescale 1ns / 1ps
// Frame predictor and word-by-word output checker for the telemetry frame serializer.
module telemetry_frame_serializer_chk
	import tfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [15:0] value_a,
	input  logic signed [15:0] value_b,
	input  logic signed [15:0] value_c,
	input  logic signed [15:0] value_d,
	input  logic signed [15:0] value_e,
	input  logic signed [15:0] value_f,
	input  logic [7:0]         status_byte,
	input  logic [15:0]        item_id,
	input  logic signed [31:0] param_value,
	input  logic [7:0]         ack_sum,
	input  logic [7:0]         ack_add,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         frame_byte,
	input  logic               last_byte,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		byte_t data;
		logic  last;
	} frame_word_t;

	frame_word_t frame_words_due[$];

	// Build the whole frame for one request and queue its words.
	function automatic void predict_frame();
		logic [15:0] vals [6];
		byte_t       frame [19];
		byte_t       sum_chk;
		byte_t       add_chk;
		frame_word_t w;
		int          nvals;
		int          n;
		vals[0] = value_a;
		vals[1] = value_b;
		vals[2] = value_c;
		vals[3] = value_d;
		vals[4] = value_e;
		vals[5] = value_f;
		frame[0] = HDR_SYNC;
		frame[1] = HDR_ADDR;
		nvals = 3;
		n = 4;
		case (kind)
			KIND_ATT:    frame[2] = ID_ATT;
			KIND_IMU:    begin
				frame[2] = ID_IMU;
				nvals = 6;
			end
			KIND_MOTOR:  begin
				frame[2] = ID_MOTOR;
				nvals = 4;
			end
			KIND_TARGET: frame[2] = ID_TARGET;
			KIND_SPEED:  frame[2] = ID_SPEED;
			KIND_ACK:    frame[2] = ID_ACK;
			KIND_PARAM:  frame[2] = ID_PARAM;
			default:     return;
		endcase
		if (kind == KIND_ACK) begin
			frame[4] = item_id[7:0];
			frame[5] = ack_sum;
			frame[6] = ack_add;
			n = 7;
		end else if (kind == KIND_PARAM) begin
			frame[4] = item_id[7:0];
			frame[5] = item_id[15:8];
			for (int i = 0; i < 4; i++)
				frame[6 + i] = param_value[8*i +: 8];
			n = 10;
		end else begin
			for (int i = 0; i < nvals; i++) begin
				frame[n]     = vals[i][7:0];
				frame[n + 1] = vals[i][15:8];
				n = n + 2;
			end
			if (kind == KIND_ATT || kind == KIND_IMU) begin
				frame[n] = status_byte;
				n = n + 1;
			end
		end
		frame[3] = byte_t'(n - 4);
		sum_chk = '0;
		add_chk = '0;
		for (int i = 0; i < n; i++) begin
			sum_chk = sum_chk + frame[i];
			add_chk = add_chk + sum_chk;
			w.data = frame[i];
			w.last = 1'b0;
			frame_words_due.push_back(w);
		end
		w.data = sum_chk;
		w.last = 1'b0;
		frame_words_due.push_back(w);
		w.data = add_chk;
		w.last = 1'b1;
		frame_words_due.push_back(w);
	endfunction

	always @(posedge clk) begin : watch
		frame_word_t w;
		if (!arst_n) begin
			frame_words_due.delete();
		end else begin
			if (in_valid && in_ready)
				predict_frame();
			if (out_valid && out_ready) begin
				if (frame_words_due.size() == 0) begin
					$display("%0t: unexpected word frame_byte=%h last_byte=%b",
						$time, frame_byte, last_byte);
					errors = errors + 1;
				end else begin
					w = frame_words_due.pop_front();
					if (frame_byte !== w.data) begin
						$display("%0t: frame_byte expected %h actual %h",
							$time, w.data, frame_byte);
						errors = errors + 1;
					end
					if (last_byte !== w.last) begin
						$display("%0t: last_byte expected %b actual %b",
							$time, w.last, last_byte);
						errors = errors + 1;
					end
				end
			end
		end
		pending = frame_words_due.size();
	end

endmodule

>>> sim/telemetry_frame_serializer_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the telemetry frame serializer: stimulus, flow control and verdict.
module telemetry_frame_serializer_tb;
	import tfs_pkg::*;

	// Kind 7 has no frame; the block takes the request and drops it.
	localparam kind_t KIND_UNDEF      = 3'd7;
	// No handshake on either side for this long means the block is hung.
	localparam int    WATCHDOG_CYCLES = 2000;
	// Long receiver hold-off; far longer than one 19-word frame.
	localparam int    HOLD_CYCLES     = 90;
	// Quiet time after the last word, a couple of frame times.
	localparam int    DRAIN_CYCLES    = 40;
	localparam int    RANDOM_PER_PHASE = 72;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic [15:0] e;
		logic [15:0] f;
		byte_t       status;
		logic [15:0] item;
		logic [31:0] pv;
		byte_t       asum;
		byte_t       aadd;
	} request_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [2:0]         kind        = '0;
	logic signed [15:0] value_a     = '0;
	logic signed [15:0] value_b     = '0;
	logic signed [15:0] value_c     = '0;
	logic signed [15:0] value_d     = '0;
	logic signed [15:0] value_e     = '0;
	logic signed [15:0] value_f     = '0;
	logic [7:0]         status_byte = '0;
	logic [15:0]        item_id     = '0;
	logic signed [31:0] param_value = '0;
	logic [7:0]         ack_sum     = '0;
	logic [7:0]         ack_add     = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [7:0]         frame_byte;
	logic               last_byte;

	int chk_errors;
	int words_pending;

	// Flow-control knobs: percent of cycles the sender idles / receiver stalls.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// Bumped to ask the receiver for one long hold-off.
	int hold_seq       = 0;
	int quiet_cycles   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	telemetry_frame_serializer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.value_a     (value_a),
		.value_b     (value_b),
		.value_c     (value_c),
		.value_d     (value_d),
		.value_e     (value_e),
		.value_f     (value_f),
		.status_byte (status_byte),
		.item_id     (item_id),
		.param_value (param_value),
		.ack_sum     (ack_sum),
		.ack_add     (ack_add),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	telemetry_frame_serializer_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.value_a     (value_a),
		.value_b     (value_b),
		.value_c     (value_c),
		.value_d     (value_d),
		.value_e     (value_e),
		.value_f     (value_f),
		.status_byte (status_byte),
		.item_id     (item_id),
		.param_value (param_value),
		.ack_sum     (ack_sum),
		.ack_add     (ack_add),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte),
		.errors      (chk_errors),
		.pending     (words_pending)
	);

	// Extremes show up often so sign bits and carries in the checks get exercised.
	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic byte_t rand8();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand32();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Every field gets random content, used or not; the block must ignore the rest.
	// A small share of undefined kinds is mixed in as noise.
	function automatic request_t rand_request();
		request_t r;
		if ($urandom_range(0, 99) < 5)
			r.kind = KIND_UNDEF;
		else
			r.kind = kind_t'($urandom_range(0, 6));
		r.a      = rand16();
		r.b      = rand16();
		r.c      = rand16();
		r.d      = rand16();
		r.e      = rand16();
		r.f      = rand16();
		r.status = rand8();
		r.item   = rand16();
		r.pv     = rand32();
		r.asum   = rand8();
		r.aadd   = rand8();
		return r;
	endfunction

	// Same pattern in every field: all-zero and all-ones frames per kind.
	function automatic request_t filled_request(kind_t k, logic fill);
		request_t r;
		r      = '0;
		r.kind = k;
		if (fill) begin
			r   = '1;
			r.kind = k;
		end
		return r;
	endfunction

	// Offer one request word. Valid stays up until taken; all changes are at the
	// falling edge, and acceptance is judged at the rising edge.
	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind        = r.kind;
		value_a     = r.a;
		value_b     = r.b;
		value_c     = r.c;
		value_d     = r.d;
		value_e     = r.e;
		value_f     = r.f;
		status_byte = r.status;
		item_id     = r.item;
		param_value = r.pv;
		ack_sum     = r.asum;
		ack_add     = r.aadd;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off whenever hold_seq moves.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: any handshake on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("telemetry_frame_serializer verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		request_t r;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every kind (undefined one included) with all-zero and
		// all-ones fields, then signed extremes and byte-order checks.
		for (int k = 0; k < 8; k++) begin
			send_request(filled_request(kind_t'(k), 1'b0));
			send_request(filled_request(kind_t'(k), 1'b1));
		end
		r        = '0;
		r.kind   = KIND_IMU;
		r.a      = 16'h7FFF;
		r.b      = 16'h8000;
		r.c      = 16'h0001;
		r.d      = 16'hFFFE;
		r.e      = 16'h5555;
		r.f      = 16'hAAAA;
		r.status = 8'h5A;
		send_request(r);
		// Parameter frame: id and value go out low byte first.
		r        = '0;
		r.kind   = KIND_PARAM;
		r.item   = 16'h1234;
		r.pv     = 32'h8000_0000;
		send_request(r);
		r.item   = 16'hFFFF;
		r.pv     = 32'h7FFF_FFFF;
		send_request(r);
		// Acknowledge: only the low byte of item_id is sent; no trailing byte.
		r        = '0;
		r.kind   = KIND_ACK;
		r.item   = 16'h3400;
		r.asum   = 8'hFF;
		r.aadd   = 8'h00;
		send_request(r);

		// Long receiver hold-off while requests keep coming: the output word
		// sits, the block stops taking requests, and it all must drain intact.
		hold_seq <= hold_seq + 1;
		repeat (8) send_request(rand_request());
		in_valid = 1'b0;
		// Sender pauses until every queued word is out.
		while (words_pending != 0)
			@(negedge clk);

		// Random phases: free flow, idle sender, stalling receiver, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct   = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct   = 61;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct   = 0;
					recv_stall_pct <= 61;
				end
				default: begin
					send_idle_pct   = 26;
					recv_stall_pct <= 26;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_request(rand_request());
		end
		in_valid = 1'b0;

		while (words_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (chk_errors == 0 && words_pending == 0)
			$display("telemetry_frame_serializer verification clean");
		else
			$display("telemetry_frame_serializer verification failed");
		$finish;
	end

endmodule
